// ----- sv/dotq_pkg.sv -----
package dotq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int ID_BITS_DEF   = 16;

    // Field widths of the ports at the default parameters
    localparam int CMD_W    = 2;
    localparam int IDENT_W  = 16;
    localparam int TIME_W   = 48;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_EXPIRE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic do_insert; // shift-insert the latched timer
        logic do_remove; // remove the matched entry
        logic pop_head;  // remove entry 0
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic   found;      // latched id is pending
        logic   full;
        logic   head_due;   // entry 0 expires at the latched now
        logic   more_due;   // entry 1 expires too
        cmd_t   op;
    } dp_stat_t;

endpackage

// ----- sv/dotq_datapath.sv -----
module dotq_datapath #(
    parameter int DEPTH     = dotq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = dotq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = dotq_pkg::ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dotq_pkg::dp_cmd_t               cmd_in,
    output dotq_pkg::dp_stat_t              stat,
    input  logic [dotq_pkg::CMD_W-1:0]      in_cmd,
    input  logic [ID_BITS-1:0]              in_ident,
    input  logic [TIME_BITS-1:0]            in_deadline,
    input  logic [TIME_BITS-1:0]            in_now,
    output logic                            changed,
    output logic [ID_BITS-1:0]              head_ident,
    output logic                            next_valid,
    output logic [TIME_BITS-1:0]            next_deadline
);
    import dotq_pkg::*;

    // Sorted chain: entry 0 is earliest; valid bits are a thermometer
    logic [DEPTH-1:0]     valid_reg, valid_next;
    logic [ID_BITS-1:0]   ident_reg [DEPTH];
    logic [ID_BITS-1:0]   ident_next [DEPTH];
    logic [TIME_BITS-1:0] dl_reg [DEPTH];
    logic [TIME_BITS-1:0] dl_next [DEPTH];

    // Latched item
    cmd_t                 op_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] tdl_reg;

    // Per-cell compare results, registered
    logic [DEPTH-1:0] match_reg, prec_reg, due_reg;
    logic [DEPTH-1:0] match_c, prec_c, due_c;
    logic             found_reg;
    logic             changed_reg;

    // First entry left pending once the due prefix is gone
    logic [DEPTH-1:0]     rest_sel;
    logic [TIME_BITS-1:0] rest_dl;

    // Cell compares against the item on the input ports at capture
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_c[i] = valid_reg[i] && (ident_reg[i] == in_ident);
            prec_c[i]  = valid_reg[i] &&
                ((dl_reg[i] < in_deadline) ||
                 ((dl_reg[i] == in_deadline) && (ident_reg[i] < in_ident)));
            due_c[i]   = valid_reg[i] && (dl_reg[i] < in_now);
        end
    end

    // Cell update: insert shifts up past prec cells, remove shifts down
    always_comb
    begin
        logic [DEPTH-1:0] below;
        valid_next = valid_reg;
        below = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            ident_next[i] = ident_reg[i];
            dl_next[i]    = dl_reg[i];
        end
        for (int i = 1; i < DEPTH; i++)
            below[i] = below[i-1] | match_reg[i-1];
        if (cmd_in.do_insert)
        begin
            valid_next = {valid_reg[DEPTH-2:0], 1'b1};
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!prec_reg[i])
                begin
                    if (i == 0 || prec_reg[(i == 0) ? 0 : i-1])
                    begin
                        ident_next[i] = id_reg;
                        dl_next[i]    = tdl_reg;
                    end
                    else
                    begin
                        ident_next[i] = ident_reg[(i == 0) ? 0 : i-1];
                        dl_next[i]    = dl_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
        else if (cmd_in.do_remove || cmd_in.pop_head)
        begin
            valid_next = {1'b0, valid_reg[DEPTH-1:1]};
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (cmd_in.pop_head || below[i] || match_reg[i])
                begin
                    ident_next[i] = ident_reg[i+1];
                    dl_next[i]    = dl_reg[i+1];
                end
            end
        end
    end

    // Due entries form a prefix; pick the entry just past it
    always_comb
    begin
        rest_sel = valid_reg & ~due_reg & {due_reg[DEPTH-2:0], 1'b1};
        rest_dl  = '0;
        for (int i = 0; i < DEPTH; i++)
            if (rest_sel[i])
                rest_dl = rest_dl | dl_reg[i];
    end

    // Head once the whole operation is done
    always_comb
    begin
        next_valid    = valid_reg[0];
        next_deadline = dl_reg[0];
        if (cmd_in.do_insert)
        begin
            next_valid = 1'b1;
            if (!prec_reg[0])
                next_deadline = tdl_reg;
        end
        else if (cmd_in.do_remove && match_reg[0])
        begin
            next_valid    = valid_reg[1];
            next_deadline = dl_reg[1];
        end
        else if (op_reg == CMD_EXPIRE)
        begin
            next_valid    = |(valid_reg & ~due_reg);
            next_deadline = rest_dl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            op_reg      <= CMD_NOP;
            match_reg   <= '0;
            prec_reg    <= '0;
            due_reg     <= '0;
            found_reg   <= 1'b0;
            changed_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd_in.capture)
            begin
                op_reg      <= cmd_t'(in_cmd);
                match_reg   <= match_c;
                prec_reg    <= prec_c;
                due_reg     <= due_c;
                found_reg   <= |match_c;
                changed_reg <= !valid_reg[0] || (in_deadline < dl_reg[0]);
            end
            else if (cmd_in.pop_head)
                due_reg <= {1'b0, due_reg[DEPTH-1:1]};
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ident_reg[i] <= ident_next[i];
            dl_reg[i]    <= dl_next[i];
        end
        if (cmd_in.capture)
        begin
            id_reg  <= in_ident;
            tdl_reg <= in_deadline;
        end
    end

    assign stat.found    = found_reg;
    assign stat.full     = valid_reg[DEPTH-1];
    assign stat.head_due = due_reg[0];
    assign stat.more_due = due_reg[1];
    assign stat.op       = op_reg;

    assign changed       = changed_reg;
    assign head_ident    = ident_reg[0];

endmodule

// ----- sv/dotq_ctrl.sv -----
module dotq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                out_busy,   // output register full and stalled
    output logic                out_load,
    output logic [dotq_pkg::STATUS_W-1:0] out_status,
    output logic                out_expired,
    output logic                out_last,
    output logic                out_chg,
    output dotq_pkg::dp_cmd_t   dp_cmd,
    input  dotq_pkg::dp_stat_t  dp_stat
);
    import dotq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Sequencer: capture, then one result per cycle while the output is not busy
    always_comb
    begin
        state_next  = state_reg;
        dp_cmd      = '0;
        out_load    = 1'b0;
        out_status  = ST_OK;
        out_expired = 1'b0;
        out_last    = 1'b1;
        out_chg     = 1'b0;
        in_stall    = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_busy)
                begin
                    state_next = S_IDLE;
                    out_load   = 1'b1;
                    unique case (dp_stat.op)
                        CMD_INSERT:
                        begin
                            if (dp_stat.found)
                                out_status = ST_DUPLICATE;
                            else if (dp_stat.full)
                                out_status = ST_FULL;
                            else
                            begin
                                dp_cmd.do_insert = 1'b1;
                                out_chg = 1'b1;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            if (dp_stat.found)
                                dp_cmd.do_remove = 1'b1;
                            else
                                out_status = ST_NOT_FOUND;
                        end
                        CMD_EXPIRE:
                        begin
                            // one due timer per cycle; stay while more are due
                            if (dp_stat.head_due)
                            begin
                                dp_cmd.pop_head = 1'b1;
                                out_expired = 1'b1;
                                out_last    = !dp_stat.more_due;
                                if (dp_stat.more_due)
                                    state_next = S_EXEC;
                            end
                        end
                        CMD_NOP:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- sv/dotq_out.sv -----
module dotq_out #(
    parameter int ID_BITS   = dotq_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = dotq_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [dotq_pkg::STATUS_W-1:0]   load_status,
    input  logic                            load_chg,
    input  logic                            load_expired,
    input  logic [ID_BITS-1:0]              load_ident,
    input  logic                            load_last,
    input  logic                            next_valid_in,
    input  logic [TIME_BITS-1:0]            next_deadline_in,
    output logic                            busy,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dotq_pkg::STATUS_W-1:0]   status,
    output logic                            earliest_changed,
    output logic                            expired_valid,
    output logic [ID_BITS-1:0]              expired_ident,
    output logic                            next_valid,
    output logic [TIME_BITS-1:0]            next_deadline,
    output logic                            last
);
    import dotq_pkg::*;

    logic                 ov_reg;
    logic [STATUS_W-1:0]  st_reg;
    logic                 chg_reg, ev_reg, nv_reg, last_reg;
    logic [ID_BITS-1:0]   eid_reg;
    logic [TIME_BITS-1:0] nd_reg;
    logic                 free;

    assign free = !ov_reg || !out_stall;
    assign busy = !free;

    // Output register; payload holds while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (free)
            ov_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            st_reg   <= load_status;
            chg_reg  <= load_chg;
            ev_reg   <= load_expired;
            eid_reg  <= load_expired ? load_ident : '0;
            last_reg <= load_last;
            nv_reg   <= next_valid_in;
            nd_reg   <= next_valid_in ? next_deadline_in : '0;
        end
    end

    assign out_valid        = ov_reg;
    assign status           = st_reg;
    assign earliest_changed = chg_reg;
    assign expired_valid    = ev_reg;
    assign expired_ident    = eid_reg;
    assign next_valid       = nv_reg;
    assign next_deadline    = nd_reg;
    assign last             = last_reg;

endmodule

// ----- sv/deadline_ordered_timer_queue_top.sv -----
// Sorted timer queue: up to DEPTH timers held in a shift chain ordered by
// deadline then id. An accepted item is compared against every entry in the
// capture cycle; the execute state then updates the chain and loads the
// result once the output register is free. Expire pops one due timer per
// cycle while the output is not stalled, emitting the popped ids earliest
// first with last on the final one; an expire that finds nothing due gives
// one empty item. next_deadline in every item is the head after the whole
// operation. Input is taken only while no operation is in progress, and the
// sequencer waits whenever the output register is full and stalled.
module deadline_ordered_timer_queue_top #(
    parameter int DEPTH     = dotq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = dotq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = dotq_pkg::ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dotq_pkg::CMD_W-1:0]      cmd,
    input  logic [ID_BITS-1:0]              timer_ident,
    input  logic [TIME_BITS-1:0]            deadline,
    input  logic [TIME_BITS-1:0]            now_time,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dotq_pkg::STATUS_W-1:0]   status,
    output logic                            earliest_changed,
    output logic                            expired_valid,
    output logic [ID_BITS-1:0]              expired_ident,
    output logic                            next_valid,
    output logic [TIME_BITS-1:0]            next_deadline,
    output logic                            last
);
    import dotq_pkg::*;

    dp_cmd_t              dp_cmd;
    dp_stat_t             dp_stat;
    logic                 chg, busy, load, ld_chg, ld_exp, ld_last;
    logic [STATUS_W-1:0]  ld_status;
    logic [ID_BITS-1:0]   head_ident;
    logic                 nv_after;
    logic [TIME_BITS-1:0] nd_after;

    dotq_datapath #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd_in(dp_cmd), .stat(dp_stat),
        .in_cmd(cmd), .in_ident(timer_ident), .in_deadline(deadline),
        .in_now(now_time), .changed(chg), .head_ident(head_ident),
        .next_valid(nv_after), .next_deadline(nd_after)
    );

    dotq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_busy(busy), .out_load(load), .out_status(ld_status),
        .out_expired(ld_exp), .out_last(ld_last), .out_chg(ld_chg),
        .dp_cmd(dp_cmd), .dp_stat(dp_stat)
    );

    dotq_out #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_out (
        .clk(clk), .rst_n(rst_n),
        .load(load), .load_status(ld_status), .load_chg(ld_chg & chg),
        .load_expired(ld_exp), .load_ident(head_ident), .load_last(ld_last),
        .next_valid_in(nv_after), .next_deadline_in(nd_after),
        .busy(busy), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .earliest_changed(earliest_changed),
        .expired_valid(expired_valid), .expired_ident(expired_ident),
        .next_valid(next_valid), .next_deadline(next_deadline), .last(last)
    );

endmodule

// ----- sim/tb_deadline_ordered_timer_queue_top.sv -----
module tb_deadline_ordered_timer_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dotq_pkg::*;

    localparam int SLOTS       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // One expected output item
    typedef struct {
        status_t             st;
        logic                changed;
        logic                exp_vld;
        logic [IDENT_W-1:0]  exp_id;
        logic                nxt_vld;
        logic [TIME_W-1:0]   nxt_dl;
        logic                lst;
    } timer_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [IDENT_W-1:0]   timer_ident;
    logic [TIME_W-1:0]    deadline;
    logic [TIME_W-1:0]    now_time;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic                 earliest_changed;
    logic                 expired_valid;
    logic [IDENT_W-1:0]   expired_ident;
    logic                 next_valid;
    logic [TIME_W-1:0]    next_deadline;
    logic                 last;

    // Shadow copy of the sorted timer table
    logic [IDENT_W-1:0]   shadow_id [SLOTS];
    logic [TIME_W-1:0]    shadow_dl [SLOTS];
    int                   shadow_cnt;

    timer_result_t        pending_results[$];
    int                   err_count;
    int                   items_sent;
    int                   results_seen;
    int                   expired_seen;
    int                   full_seen;
    int                   burst_left;
    int                   hold_len;
    logic                 hold_on;
    int                   cycle_count;
    logic [TIME_W-1:0]    time_base;

    deadline_ordered_timer_queue_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .timer_ident      (timer_ident),
        .deadline         (deadline),
        .now_time         (now_time),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .earliest_changed (earliest_changed),
        .expired_valid    (expired_valid),
        .expired_ident    (expired_ident),
        .next_valid       (next_valid),
        .next_deadline    (next_deadline),
        .last             (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int find_slot(logic [IDENT_W-1:0] id);
        for (int i = 0; i < shadow_cnt; i++)
            if (shadow_id[i] == id)
                return i;
        return -1;
    endfunction

    task automatic drop_slot(int pos);
        for (int i = pos; i + 1 < shadow_cnt; i++)
        begin
            shadow_id[i] = shadow_id[i + 1];
            shadow_dl[i] = shadow_dl[i + 1];
        end
        shadow_cnt--;
    endtask

    task automatic queue_result(status_t st, logic chg, logic ev, logic [IDENT_W-1:0] eid,
                                logic lst);
        timer_result_t r;
        r.st      = st;
        r.changed = chg;
        r.exp_vld = ev;
        r.exp_id  = eid;
        r.nxt_vld = (shadow_cnt > 0);
        r.nxt_dl  = (shadow_cnt > 0) ? shadow_dl[0] : '0;
        r.lst     = lst;
        pending_results.push_back(r);
    endtask

    // Apply one accepted operation to the shadow table and queue its results
    task automatic predict_timer_op(cmd_t op, logic [IDENT_W-1:0] id,
                                    logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
        logic [IDENT_W-1:0] popped[$];
        int pos;
        logic chg;
        case (op)
            CMD_INSERT:
            begin
                if (find_slot(id) >= 0)
                    queue_result(ST_DUPLICATE, 1'b0, 1'b0, '0, 1'b1);
                else if (shadow_cnt >= SLOTS)
                begin
                    full_seen++;
                    queue_result(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    chg = (shadow_cnt == 0) || (dl < shadow_dl[0]);
                    pos = 0;
                    while (pos < shadow_cnt && (shadow_dl[pos] < dl ||
                           (shadow_dl[pos] == dl && shadow_id[pos] < id)))
                        pos++;
                    for (int i = shadow_cnt; i > pos; i--)
                    begin
                        shadow_id[i] = shadow_id[i - 1];
                        shadow_dl[i] = shadow_dl[i - 1];
                    end
                    shadow_id[pos] = id;
                    shadow_dl[pos] = dl;
                    shadow_cnt++;
                    queue_result(ST_OK, chg, 1'b0, '0, 1'b1);
                end
            end
            CMD_CANCEL:
            begin
                pos = find_slot(id);
                if (pos < 0)
                    queue_result(ST_NOT_FOUND, 1'b0, 1'b0, '0, 1'b1);
                else
                begin
                    drop_slot(pos);
                    queue_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            CMD_EXPIRE:
            begin
                while (shadow_cnt > 0 && shadow_dl[0] < now)
                begin
                    popped.push_back(shadow_id[0]);
                    drop_slot(0);
                end
                if (popped.size() == 0)
                    queue_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
                foreach (popped[k])
                    queue_result(ST_OK, 1'b0, 1'b1, popped[k], k == popped.size() - 1);
            end
            default:
                queue_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
        endcase
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, field, got, want);
        err_count++;
    endtask

    // Send one item; bursts of random length separated by random gaps
    task automatic send_item(cmd_t op, logic [IDENT_W-1:0] id,
                             logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        timer_ident <= id;
        deadline    <= dl;
        now_time    <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_timer_op(op, id, dl, now);
        burst_left--;
        items_sent++;
    endtask

    // Stop sending and wait for every expected item
    task automatic drain_results();
        in_valid    <= 1'b0;
        burst_left  = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Long receiver hold-off, counted down in its own process
    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            hold_on  <= 1'b1;
            hold_len <= hold_len - 1;
        end
        else
            hold_on <= 1'b0;
    end

    // Receiver: stall pattern cycling through three modes, plus checking
    always @(posedge clk)
    begin
        timer_result_t want;
        int stall_mode;
        stall_mode = (cycle_count / 64) % 3;
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_on ||
                         (stall_mode == 1 && $urandom_range(0, 3) == 0) ||
                         (stall_mode == 2 && $urandom_range(0, 9) < 6);
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("unexpected item at result %0d", results_seen);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (expired_valid)
                    expired_seen++;
                if (status !== want.st)
                    report_mismatch("status", 64'(status), 64'(want.st));
                if (earliest_changed !== want.changed)
                    report_mismatch("earliest_changed", 64'(earliest_changed),
                                    64'(want.changed));
                if (expired_valid !== want.exp_vld)
                    report_mismatch("expired_valid", 64'(expired_valid), 64'(want.exp_vld));
                if (expired_ident !== want.exp_id)
                    report_mismatch("expired_ident", 64'(expired_ident), 64'(want.exp_id));
                if (next_valid !== want.nxt_vld)
                    report_mismatch("next_valid", 64'(next_valid), 64'(want.nxt_vld));
                if (next_deadline !== want.nxt_dl)
                    report_mismatch("next_deadline", 64'(next_deadline), 64'(want.nxt_dl));
                if (last !== want.lst)
                    report_mismatch("last", 64'(last), 64'(want.lst));
            end
        end
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    // Mostly ids from a small pool so duplicates, misses and a full table happen
    function automatic logic [IDENT_W-1:0] pick_ident();
        if ($urandom_range(0, 9) == 0)
            return IDENT_W'($urandom());
        return IDENT_W'($urandom_range(0, 23));
    endfunction

    // Directed: extremes, every operation and each corner
    task automatic test_directed();
        send_item(CMD_EXPIRE, 16'h0000, '0, TIME_MAX);          // expire on empty table
        send_item(CMD_CANCEL, 16'hFFFF, '0, '0);                // cancel unknown id
        send_item(CMD_INSERT, 16'hFFFF, TIME_MAX, '0);          // max id, max deadline
        send_item(CMD_INSERT, 16'hFFFF, 48'd5, '0);             // duplicate id
        send_item(CMD_INSERT, 16'h0000, 48'd100, '0);           // new earliest
        send_item(CMD_INSERT, 16'h0007, 48'd100, '0);           // equal deadline, larger id
        send_item(CMD_INSERT, 16'h0003, 48'd100, '0);           // equal deadline, ordered by id, no change flag
        send_item(CMD_INSERT, 16'hA5A5, 48'h5A5A_5A5A_5A5A, '0);
        send_item(CMD_NOP,    16'h1234, TIME_MAX, TIME_MAX);    // unused command
        send_item(CMD_EXPIRE, 16'h0000, '0, 48'd100);           // deadline equal to now
        send_item(CMD_EXPIRE, 16'h0000, '0, 48'd101);           // three expire together
        send_item(CMD_CANCEL, 16'hA5A5, '0, '0);
        send_item(CMD_INSERT, 16'h5A5A, 48'h0000_0000_0000, '0);
        send_item(CMD_EXPIRE, 16'h0000, '0, TIME_MAX);          // clears all but max deadline
        send_item(CMD_CANCEL, 16'hFFFF, '0, '0);
        // Fill to the limit, then one more
        for (int i = 0; i < SLOTS; i++)
            send_item(CMD_INSERT, 16'(100 + i), 48'(1000 - 10 * i), '0);
        send_item(CMD_INSERT, 16'h0200, 48'd1, '0);             // table full
        send_item(CMD_INSERT, 16'h0064, 48'd1, '0);             // duplicate on full table
        send_item(CMD_EXPIRE, 16'h0000, '0, 48'd2000);          // sixteen results
        drain_results();
    endtask

    // Random mix of well-formed operations around an advancing clock
    task automatic test_random(int count);
        int pick;
        logic [TIME_W-1:0] dl;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                dl = ($urandom_range(0, 14) == 0) ? rand_time()
                                                  : time_base + TIME_W'($urandom_range(0, 300));
                send_item(CMD_INSERT, pick_ident(), dl, rand_time());
            end
            else if (pick < 70)
                send_item(CMD_CANCEL, pick_ident(), rand_time(), rand_time());
            else if (pick < 95)
            begin
                time_base = time_base + TIME_W'($urandom_range(0, 150));
                send_item(CMD_EXPIRE, IDENT_W'($urandom()), rand_time(),
                          ($urandom_range(0, 19) == 0) ? rand_time() : time_base);
            end
            else
                send_item(CMD_NOP, IDENT_W'($urandom()), rand_time(), rand_time());
        end
    endtask

    // Receiver holds off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        hold_len <= 400;
        for (int n = 0; n < 20; n++)
            send_item(CMD_INSERT, 16'(300 + n), time_base + TIME_W'($urandom_range(0, 50)),
                      '0);
        drain_results();
        send_item(CMD_EXPIRE, 16'h0000, '0, TIME_MAX);
        drain_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_NOP;
        timer_ident  = '0;
        deadline     = '0;
        now_time     = '0;
        out_stall    = 1'b0;
        hold_len     = 0;
        hold_on      = 1'b0;
        cycle_count  = 0;
        shadow_cnt   = 0;
        err_count    = 0;
        items_sent   = 0;
        results_seen = 0;
        expired_seen = 0;
        full_seen    = 0;
        burst_left   = 0;
        time_base    = 48'd1000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(50);
        test_backpressure();
        test_random(50);
        drain_results();
        repeat (40) @(posedge clk);

        $display("covered %0d items, %0d results, %0d expired timers, %0d full-table inserts",
                 items_sent, results_seen, expired_seen, full_seen);
        if (err_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
